>>> hdl/nls_pkg.sv
// Shared types and constants for the numeric literal scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package nls_pkg;

    localparam int LEN_W      = 16;
    localparam int CHAR_W     = 16;
    localparam int FLAGS_W    = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Register map (word index = paddr[2])
    localparam logic REG_FORMAT_FLAGS = 1'b0;

    // format_flags bit positions
    localparam int FL_SIGN  = 0;
    localparam int FL_HEX   = 1;
    localparam int FL_BIN   = 2;
    localparam int FL_UNDER = 3;
    localparam int FL_FRAC  = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_ONE   = 16'h0031;
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 16'h0078;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 16'h0058;
    localparam logic [CHAR_W-1:0] CH_LO_B  = 16'h0062;
    localparam logic [CHAR_W-1:0] CH_UP_B  = 16'h0042;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 16'h0046;
    localparam logic [CHAR_W-1:0] CH_UNDER = 16'h005F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_PREFIX = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_INT    = 5'b01000,
        PH_FRAC   = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_BIN = 2'd2
    } t_base;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              first_char;
        logic              last_char;
    } t_in_item;

    typedef struct packed {
        logic [LEN_W-1:0] token_length;
        logic             reached_text_end;
    } t_out_item;

    // One result from the scan core toward the output queue
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    function automatic logic digit_ok(input logic [CHAR_W-1:0] c, input t_base base,
                                      input logic under_en);
        logic dec;
        logic hex;
        logic ok;
        dec = (c >= CH_ZERO) && (c <= CH_NINE);
        hex = dec || ((c >= CH_LO_A) && (c <= CH_LO_F)) || ((c >= CH_UP_A) && (c <= CH_UP_F));
        case (base)
            BASE_BIN: ok = (c == CH_ZERO) || (c == CH_ONE);
            BASE_HEX: ok = hex;
            default:  ok = dec;
        endcase
        return ok || (under_en && (c == CH_UNDER));
    endfunction

endpackage

`default_nettype wire

>>> hdl/nls_scan_core.sv
// Scan state machine: one character per cycle while i_step is high, emits a result on reject or text end.
// Depends on nls_pkg.
`default_nettype none

module nls_scan_core
    import nls_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire t_in_item            i_item,
    input  wire logic [FLAGS_W-1:0]  i_flags,
    output      t_result             o_result
);

    localparam int EXT_W = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

    t_phase                 r_phase, n_phase;
    t_base                  r_base,  n_base;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + LENGTH_BITS'(1);
    endfunction

    function automatic logic [LEN_W-1:0] to_len(input logic [LENGTH_BITS-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[LEN_W-1:0];
    endfunction

    always_comb begin
        t_phase                 ph;
        t_phase                 rp;
        t_base                  bs;
        logic [LENGTH_BITS-1:0] ct;
        logic [CHAR_W-1:0]      c;
        logic                   last;
        logic                   run;
        logic                   is_sign;

        n_phase  = r_phase;
        n_base   = r_base;
        n_count  = r_count;
        o_result = '0;

        c    = i_item.char_code;
        last = i_item.last_char;
        ph   = r_phase;
        bs   = r_base;
        ct   = r_count;
        run  = 1'b0;
        rp   = PH_INT;
        is_sign = (c == CH_MINUS) || (c == CH_PLUS);

        if (i_step) begin
            if (i_item.first_char) begin
                ph = PH_PREFIX;
                bs = BASE_DEC;
                ct = '0;
            end
            n_phase = ph;
            n_base  = bs;
            n_count = ct;

            if (i_item.first_char && i_flags[FL_SIGN] && is_sign) begin
                // a lone sign at text end yields an empty token
                if (last) begin
                    o_result.valid                 = 1'b1;
                    o_result.item.token_length     = to_len(ct);
                    o_result.item.reached_text_end = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_count = sat_inc(ct);
                end
            end else begin
                case (ph)
                    PH_PREFIX: begin
                        if ((c == CH_ZERO) && !last) begin
                            n_count = sat_inc(ct);
                            n_phase = PH_ZERO;
                        end else begin
                            run = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (!last && ((c == CH_LO_X) || (c == CH_UP_X)) && i_flags[FL_HEX]) begin
                            n_count = sat_inc(ct);
                            n_base  = BASE_HEX;
                            n_phase = PH_INT;
                        end else if (!last && ((c == CH_LO_B) || (c == CH_UP_B))
                                     && i_flags[FL_BIN]) begin
                            n_count = sat_inc(ct);
                            n_base  = BASE_BIN;
                            n_phase = PH_INT;
                        end else begin
                            run = 1'b1;
                        end
                    end
                    PH_INT: begin
                        run = 1'b1;
                    end
                    PH_FRAC: begin
                        run = 1'b1;
                        rp  = PH_FRAC;
                    end
                    default: begin
                    end
                endcase

                if (run) begin
                    if (digit_ok(c, (rp == PH_FRAC) ? BASE_DEC : bs, i_flags[FL_UNDER])) begin
                        n_count = sat_inc(ct);
                        n_phase = last ? PH_IDLE : rp;
                        o_result.valid                 = last;
                        o_result.item.token_length     = to_len(sat_inc(ct));
                        o_result.item.reached_text_end = 1'b1;
                    end else if ((rp == PH_INT) && (bs == BASE_DEC) && (c == CH_DOT)
                                 && i_flags[FL_FRAC]) begin
                        // dot is taken even with no fraction digits after it
                        n_count = sat_inc(ct);
                        n_phase = last ? PH_IDLE : PH_FRAC;
                        o_result.valid                 = last;
                        o_result.item.token_length     = to_len(sat_inc(ct));
                        o_result.item.reached_text_end = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                        o_result.valid                 = 1'b1;
                        o_result.item.token_length     = to_len(ct);
                        o_result.item.reached_text_end = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_base  <= BASE_DEC;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> hdl/nls_out_queue.sv
// Small result queue between the scan core and the output channel.
// Depends on nls_pkg.
`default_nettype none

module nls_out_queue
    import nls_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_result                i_push,
    output      logic                   o_valid,
    output      t_out_item              o_item,
    input  wire logic                   i_stall,
    output      logic [QUEUE_CNT_W-1:0] o_level
);

    t_out_item              r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_cnt,    n_cnt;
    logic                   pop;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_level = r_cnt;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_PTR_W'(i_push.valid);
        n_rd_ptr = r_rd_ptr + QUEUE_PTR_W'(pop);
        n_cnt    = r_cnt + QUEUE_CNT_W'(i_push.valid) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hdl/numeric_literal_scanner.sv
// Numeric literal scanner top level: input register, config register, scan core, result queue.
// Depends on nls_pkg, nls_scan_core, nls_out_queue.
//
// Takes one UTF-16 character per cycle while o_in_stall is low, from a token start (first_char),
// and reports the length of the numeric literal found there once a character is rejected or
// the text ends. A character is scanned while it sits in the input register, and its result,
// if any, is written into the queue at the next edge, which raises o_out_valid. The scan state
// is a single phase/base/count register set updated once per character, which sets the rate
// at one item per cycle while the input is not stalled. Results collect in a four-entry queue;
// the input stalls only when the queue plus the character in flight could fill it. format_flags
// is written over APB at address 0 and should only change while no scan is in progress.
`default_nettype none

module numeric_literal_scanner
    import nls_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // character input
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire t_in_item              i_in_item,
    // result output
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      t_out_item             o_out_item,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    logic [FLAGS_W-1:0]     r_flags;
    logic                   r_in_valid;
    t_in_item               r_in_item;
    t_result                scan_result;
    logic [QUEUE_CNT_W-1:0] queue_level;
    logic [QUEUE_CNT_W:0]   committed;
    logic                   in_accept;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_FORMAT_FLAGS) ?
                    APB_DATA_W'(r_flags) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[APB_ADDR_W-1] == REG_FORMAT_FLAGS)) begin
            r_flags <= pwdata[FLAGS_W-1:0];
        end
    end

    // room must exist for the item in the input register and the one being taken
    assign committed  = (QUEUE_CNT_W+1)'(queue_level) + (QUEUE_CNT_W+1)'(r_in_valid);
    assign o_in_stall = (committed >= (QUEUE_CNT_W+1)'(QUEUE_DEPTH));
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    nls_scan_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid),
        .i_item   (r_in_item),
        .i_flags  (r_flags),
        .o_result (scan_result)
    );

    nls_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scan_result),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall),
        .o_level (queue_level)
    );

endmodule

`default_nettype wire

>>> hdl/nls_checker.sv
// Port-level checks for the numeric literal scanner, bound to the top level.
// Depends on nls_pkg and numeric_literal_scanner.
`default_nettype none

module nls_checker
    import nls_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      o_in_stall,
    input  wire logic      o_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item o_out_item,
    input  wire logic      pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    // a result can only appear once a taken character has passed the input register into the queue
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a character");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && pready)
        else $error("output not empty after reset");

endmodule

bind numeric_literal_scanner nls_checker u_nls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .pready      (pready)
);

`default_nettype wire
